@@ design/assert_macros.svh @@
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk
`define CRMM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication, sampled on clk
`define CRMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("assertion failed");

`endif

@@ design/crmm_pkg.sv @@
package crmm_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int EXP_BITS_DEF   = 31;

  localparam int DIM       = 6;
  localparam int IDX_BITS  = 3;
  localparam int NUM_REGS  = 7;
  localparam int CFG_BITS  = 3;

  // register indexes
  localparam logic [CFG_BITS-1:0] REG_MODULUS = 3'd6;

  // matrix store: {slot, row, col}
  localparam int SLOT_BITS = 2;
  localparam int ADDR_BITS = SLOT_BITS + 2 * IDX_BITS;
  localparam int RAM_DEPTH = 1 << ADDR_BITS;

  localparam logic [SLOT_BITS-1:0] SLOT_A = 2'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_B = 2'd1;
  localparam logic [SLOT_BITS-1:0] SLOT_C = 2'd2;

  localparam logic [IDX_BITS-1:0] IDX_LAST = 3'd5;
  localparam logic [IDX_BITS-1:0] ROW_F    = 3'd0;
  localparam logic [IDX_BITS-1:0] ROW_G    = 3'd3;

  // operand index for the reduction pass: six initial values, then six coefficients
  localparam int OPI_BITS = 4;
  localparam logic [OPI_BITS-1:0] OPI_COEF0 = 4'd6;
  localparam logic [OPI_BITS-1:0] OPI_LAST  = 4'd11;

  typedef enum logic [1:0] {
    BSEL_RAW,
    BSEL_RAM,
    BSEL_VEC
  } bsel_t;

  typedef enum logic [1:0] {
    WSEL_IDENT,
    WSEL_BASE,
    WSEL_SUM
  } wsel_t;

  typedef struct packed {
    logic                 load_in;
    logic                 clr_sum;
    logic                 acc_en;
    logic                 load_opa;
    logic                 opa_one;
    logic                 start;
    bsel_t                bsel;
    logic [OPI_BITS-1:0]  bidx;
    logic                 store_red;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    wsel_t                wsel;
    logic [IDX_BITS-1:0]  row;
    logic [IDX_BITS-1:0]  col;
    logic                 save_f;
    logic                 save_g;
    logic                 put;
    logic                 put_short;
    logic [1:0]           short_sel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } status_t;

endpackage

@@ design/coupled_recurrence_mod_matpow.sv @@
// channel   direction  handshake              word
// in_       input      in_valid / in_stall    term_index, f_init0..2, g_init0..2
// out_      output     out_valid / out_stall  f_value, g_value
// cfg_      input      cfg_we                 cfg_addr, cfg_wdata
//
// one word at a time; every modular product runs on one bit-serial unit,
// which the reduction pass and each matrix multiply-add step wait on. n<3
// takes only the reduction pass of 12 products; otherwise add the matrix
// setup, up to 2*(EXP_BITS-1) 6x6 products of 216 steps each, and 12
// steps for the final row products.
// synchronous active-low reset, no clearing pass; a finished word waits in the
// output register while the next word is taken; a second finished word waits
// in the sequencer until the first one leaves, so out_stall can hold the input.
module coupled_recurrence_mod_matpow #(
  parameter int VALUE_BITS = crmm_pkg::VALUE_BITS_DEF,
  parameter int EXP_BITS   = crmm_pkg::EXP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [crmm_pkg::CFG_BITS-1:0] cfg_addr,
  input  logic [VALUE_BITS-1:0]         cfg_wdata,
  // input word
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [EXP_BITS-1:0]           in_term_index,
  input  logic [VALUE_BITS-1:0]         in_f_init0,
  input  logic [VALUE_BITS-1:0]         in_f_init1,
  input  logic [VALUE_BITS-1:0]         in_f_init2,
  input  logic [VALUE_BITS-1:0]         in_g_init0,
  input  logic [VALUE_BITS-1:0]         in_g_init1,
  input  logic [VALUE_BITS-1:0]         in_g_init2,
  // result word
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VALUE_BITS-1:0]         out_f_value,
  output logic [VALUE_BITS-1:0]         out_g_value
);

  // command bus from sequencer to datapath, status back
  crmm_pkg::cmd_t    cmd;
  crmm_pkg::status_t status;

  // sequencer: reduction pass, matrix setup, square-and-multiply, final rows
  crmm_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_term_index (in_term_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .status        (status)
  );

  // datapath: config registers, matrix store, modular multiplier, accumulator
  crmm_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .f_init0   (in_f_init0),
    .f_init1   (in_f_init1),
    .f_init2   (in_f_init2),
    .g_init0   (in_g_init0),
    .g_init1   (in_g_init1),
    .g_init2   (in_g_init2),
    .f_value   (out_f_value),
    .g_value   (out_g_value)
  );

endmodule

@@ design/crmm_ram.sv @@
module crmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/crmm_mulmod.sv @@
// bit-serial a*b mod m, b taken msb first; needs a < m
module crmm_mulmod #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CNT_BITS = $clog2(W + 1);

  logic [W-1:0]        acc_r, acc_nxt;
  logic [W-1:0]        a_r;
  logic [W-1:0]        b_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [W+1:0]        t;
  logic [W+1:0]        m1;
  logic [W+1:0]        m2;

  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : '0);
    if (t >= m2) begin
      t = t - m2;
    end else if (t >= m1) begin
      t = t - m1;
    end
    acc_nxt = t[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

@@ design/crmm_dp.sv @@
module crmm_dp #(
  parameter int VALUE_BITS = crmm_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crmm_pkg::cmd_t                cmd,
  output crmm_pkg::status_t             status,
  input  logic                          cfg_we,
  input  logic [crmm_pkg::CFG_BITS-1:0] cfg_addr,
  input  logic [VALUE_BITS-1:0]         cfg_wdata,
  input  logic [VALUE_BITS-1:0]         f_init0,
  input  logic [VALUE_BITS-1:0]         f_init1,
  input  logic [VALUE_BITS-1:0]         f_init2,
  input  logic [VALUE_BITS-1:0]         g_init0,
  input  logic [VALUE_BITS-1:0]         g_init1,
  input  logic [VALUE_BITS-1:0]         g_init2,
  output logic [VALUE_BITS-1:0]         f_value,
  output logic [VALUE_BITS-1:0]         g_value
);

  localparam int W = VALUE_BITS;

  logic [W-1:0] coef_r [crmm_pkg::DIM];
  logic [W-1:0] mod_r;
  logic [W-1:0] raw_r  [crmm_pkg::DIM];
  logic [W-1:0] vec_r  [crmm_pkg::DIM];
  logic [W-1:0] coefm_r [crmm_pkg::DIM];
  logic [W-1:0] opa_r;
  logic [W-1:0] sum_r, sum_nxt;
  logic [W-1:0] res_f_r, res_g_r;
  logic [W-1:0] out_f_r, out_g_r;

  logic [W-1:0] m_eff;
  logic [W-1:0] one_m;
  logic [W-1:0] mul_b;
  logic [W-1:0] mul_res;
  logic         mul_done;
  logic [W-1:0] rdata;
  logic [W-1:0] wdata;
  logic [W-1:0] base_val;
  logic [W:0]   s_wide;
  logic [crmm_pkg::OPI_BITS-1:0] cidx;
  logic [crmm_pkg::IDX_BITS-1:0] fsel, gsel;

  // modulus zero acts as one
  assign m_eff = (mod_r == '0) ? W'(1) : mod_r;
  assign one_m = (m_eff == W'(1)) ? '0 : W'(1);
  assign cidx  = cmd.bidx - crmm_pkg::OPI_COEF0;

  always_comb begin
    unique case (cmd.bsel)
      crmm_pkg::BSEL_RAW: begin
        if (cmd.bidx < crmm_pkg::OPI_COEF0) begin
          mul_b = raw_r[cmd.bidx[crmm_pkg::IDX_BITS-1:0]];
        end else begin
          mul_b = coef_r[cidx[crmm_pkg::IDX_BITS-1:0]];
        end
      end
      crmm_pkg::BSEL_RAM: mul_b = rdata;
      crmm_pkg::BSEL_VEC: mul_b = vec_r[cmd.bidx[crmm_pkg::IDX_BITS-1:0]];
      default:            mul_b = '0;
    endcase
  end

  // companion matrix entry, state order f2 f1 f0 g2 g1 g0
  always_comb begin
    base_val = '0;
    priority if (cmd.row == 3'd0 && cmd.col == 3'd0) base_val = coefm_r[0];
    else if (cmd.row == 3'd0 && cmd.col == 3'd1) base_val = coefm_r[1];
    else if (cmd.row == 3'd0 && cmd.col == 3'd5) base_val = coefm_r[2];
    else if (cmd.row == 3'd3 && cmd.col == 3'd3) base_val = coefm_r[3];
    else if (cmd.row == 3'd3 && cmd.col == 3'd4) base_val = coefm_r[4];
    else if (cmd.row == 3'd3 && cmd.col == 3'd2) base_val = coefm_r[5];
    else if ((cmd.row == 3'd1 && cmd.col == 3'd0) || (cmd.row == 3'd2 && cmd.col == 3'd1) ||
             (cmd.row == 3'd4 && cmd.col == 3'd3) || (cmd.row == 3'd5 && cmd.col == 3'd4))
      base_val = one_m;
    else base_val = '0;
  end

  always_comb begin
    unique case (cmd.wsel)
      crmm_pkg::WSEL_IDENT: wdata = (cmd.row == cmd.col) ? one_m : '0;
      crmm_pkg::WSEL_BASE:  wdata = base_val;
      crmm_pkg::WSEL_SUM:   wdata = sum_r;
      default:              wdata = '0;
    endcase
  end

  always_comb begin
    s_wide = {1'b0, sum_r} + {1'b0, mul_res};
    if (s_wide >= {1'b0, m_eff}) begin
      s_wide = s_wide - {1'b0, m_eff};
    end
    sum_nxt = s_wide[W-1:0];
  end

  assign fsel = 3'd2 - {1'b0, cmd.short_sel};
  assign gsel = 3'd5 - {1'b0, cmd.short_sel};

  crmm_ram #(
    .WIDTH (W),
    .DEPTH (crmm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (cmd.ram_addr),
    .wdata (wdata),
    .raddr (cmd.ram_addr),
    .rdata (rdata)
  );

  crmm_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .a      (opa_r),
    .b      (mul_b),
    .m      (m_eff),
    .done   (mul_done),
    .result (mul_res)
  );

  assign status.mul_done = mul_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < crmm_pkg::DIM; i++) begin
        coef_r[i] <= '0;
      end
      mod_r <= W'(1);
    end else if (cfg_we) begin
      if (cfg_addr < crmm_pkg::REG_MODULUS) begin
        coef_r[cfg_addr] <= cfg_wdata;
      end else if (cfg_addr == crmm_pkg::REG_MODULUS) begin
        mod_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r[0] <= f_init2;
      raw_r[1] <= f_init1;
      raw_r[2] <= f_init0;
      raw_r[3] <= g_init2;
      raw_r[4] <= g_init1;
      raw_r[5] <= g_init0;
    end
    if (cmd.store_red) begin
      if (cmd.bidx < crmm_pkg::OPI_COEF0) begin
        vec_r[cmd.bidx[crmm_pkg::IDX_BITS-1:0]] <= mul_res;
      end else begin
        coefm_r[cidx[crmm_pkg::IDX_BITS-1:0]] <= mul_res;
      end
    end
    if (cmd.load_opa) begin
      opa_r <= cmd.opa_one ? one_m : rdata;
    end
    if (cmd.clr_sum) begin
      sum_r <= '0;
    end else if (cmd.acc_en) begin
      sum_r <= sum_nxt;
    end
    if (cmd.save_f) begin
      res_f_r <= sum_r;
    end
    if (cmd.save_g) begin
      res_g_r <= sum_r;
    end
    if (cmd.put) begin
      if (cmd.put_short) begin
        out_f_r <= vec_r[fsel];
        out_g_r <= vec_r[gsel];
      end else begin
        out_f_r <= res_f_r;
        out_g_r <= res_g_r;
      end
    end
  end

  assign f_value = out_f_r;
  assign g_value = out_g_r;

endmodule

@@ design/crmm_ctrl.sv @@
module crmm_ctrl #(
  parameter int EXP_BITS = crmm_pkg::EXP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [EXP_BITS-1:0] in_term_index,
  output logic                out_valid,
  input  logic                out_stall,
  output crmm_pkg::cmd_t      cmd,
  input  crmm_pkg::status_t   status
);

  typedef enum logic [4:0] {
    S_IDLE, S_RLD, S_RMS, S_RMW, S_INIT, S_LOOP, S_SHIFT,
    S_MRA, S_MLA, S_MMS, S_MMW, S_MWR, S_MEND,
    S_FRA, S_FLA, S_FMS, S_FMW, S_FSV, S_PUT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [EXP_BITS-1:0]              n_r, n_nxt;
  logic [EXP_BITS-1:0]              e_r, e_nxt;
  logic [crmm_pkg::OPI_BITS-1:0]    ridx_r, ridx_nxt;
  logic [crmm_pkg::IDX_BITS-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                             isel_r, isel_nxt;
  logic                             sq_r, sq_nxt;
  logic                             short_r, short_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [crmm_pkg::SLOT_BITS-1:0]   sa_r, sa_nxt, sb_r, sb_nxt, sf_r, sf_nxt;
  logic [EXP_BITS-1:0]              e_half;

  assign e_half = e_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    ridx_nxt      = ridx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    isel_nxt      = isel_r;
    sq_nxt        = sq_r;
    short_nxt     = short_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    sf_nxt        = sf_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.bsel      = crmm_pkg::BSEL_RAW;
    cmd.wsel      = crmm_pkg::WSEL_IDENT;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.clr_sum = 1'b1;
          n_nxt       = in_term_index;
          ridx_nxt    = '0;
          short_nxt   = 1'b0;
          state_nxt   = S_RLD;
        end
      end
      S_RLD: begin
        cmd.load_opa = 1'b1;
        cmd.opa_one  = 1'b1;
        state_nxt    = S_RMS;
      end
      S_RMS: begin
        cmd.start = 1'b1;
        cmd.bidx  = ridx_r;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        cmd.bidx = ridx_r;
        if (status.mul_done) begin
          cmd.store_red = 1'b1;
          if (ridx_r == crmm_pkg::OPI_LAST) begin
            if (n_r < EXP_BITS'(3)) begin
              short_nxt = 1'b1;
              state_nxt = S_PUT;
            end else begin
              e_nxt     = n_r - EXP_BITS'(2);
              i_nxt     = '0;
              j_nxt     = '0;
              isel_nxt  = 1'b0;
              sa_nxt    = crmm_pkg::SLOT_A;
              sb_nxt    = crmm_pkg::SLOT_B;
              sf_nxt    = crmm_pkg::SLOT_C;
              state_nxt = S_INIT;
            end
          end else begin
            ridx_nxt  = ridx_r + 1'b1;
            state_nxt = S_RLD;
          end
        end
      end
      S_INIT: begin
        cmd.ram_we   = 1'b1;
        cmd.row      = i_r;
        cmd.col      = j_r;
        cmd.wsel     = isel_r ? crmm_pkg::WSEL_BASE : crmm_pkg::WSEL_IDENT;
        cmd.ram_addr = {isel_r ? crmm_pkg::SLOT_B : crmm_pkg::SLOT_A, i_r, j_r};
        if (j_r == crmm_pkg::IDX_LAST) begin
          j_nxt = '0;
          if (i_r == crmm_pkg::IDX_LAST) begin
            i_nxt = '0;
            if (isel_r) begin
              state_nxt = S_LOOP;
            end else begin
              isel_nxt = 1'b1;
            end
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_LOOP: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        if (e_r[0]) begin
          sq_nxt    = 1'b0;
          state_nxt = S_MRA;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        e_nxt = e_half;
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        if (e_half != '0) begin
          sq_nxt    = 1'b1;
          state_nxt = S_MRA;
        end else begin
          i_nxt     = crmm_pkg::ROW_F;
          state_nxt = S_FRA;
        end
      end
      S_MRA: begin
        cmd.ram_addr = {sq_r ? sb_r : sa_r, i_r, k_r};
        state_nxt    = S_MLA;
      end
      S_MLA: begin
        cmd.load_opa = 1'b1;
        cmd.ram_addr = {sb_r, k_r, j_r};
        state_nxt    = S_MMS;
      end
      S_MMS: begin
        cmd.start = 1'b1;
        cmd.bsel  = crmm_pkg::BSEL_RAM;
        state_nxt = S_MMW;
      end
      S_MMW: begin
        if (status.mul_done) begin
          cmd.acc_en = 1'b1;
          if (k_r == crmm_pkg::IDX_LAST) begin
            state_nxt = S_MWR;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_MRA;
          end
        end
      end
      S_MWR: begin
        cmd.ram_we   = 1'b1;
        cmd.wsel     = crmm_pkg::WSEL_SUM;
        cmd.ram_addr = {sf_r, i_r, j_r};
        cmd.clr_sum  = 1'b1;
        k_nxt        = '0;
        state_nxt    = S_MRA;
        if (j_r == crmm_pkg::IDX_LAST) begin
          j_nxt = '0;
          if (i_r == crmm_pkg::IDX_LAST) begin
            state_nxt = S_MEND;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_MEND: begin
        // product landed in the free slot: rename instead of copying
        sf_nxt = sq_r ? sb_r : sa_r;
        if (sq_r) begin
          sb_nxt    = sf_r;
          state_nxt = S_LOOP;
        end else begin
          sa_nxt    = sf_r;
          state_nxt = S_SHIFT;
        end
      end
      S_FRA: begin
        cmd.ram_addr = {sa_r, i_r, k_r};
        state_nxt    = S_FLA;
      end
      S_FLA: begin
        cmd.load_opa = 1'b1;
        state_nxt    = S_FMS;
      end
      S_FMS: begin
        cmd.start = 1'b1;
        cmd.bsel  = crmm_pkg::BSEL_VEC;
        cmd.bidx  = {1'b0, k_r};
        state_nxt = S_FMW;
      end
      S_FMW: begin
        if (status.mul_done) begin
          cmd.acc_en = 1'b1;
          if (k_r == crmm_pkg::IDX_LAST) begin
            state_nxt = S_FSV;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_FRA;
          end
        end
      end
      S_FSV: begin
        cmd.clr_sum = 1'b1;
        k_nxt       = '0;
        if (i_r == crmm_pkg::ROW_F) begin
          cmd.save_f = 1'b1;
          i_nxt      = crmm_pkg::ROW_G;
          state_nxt  = S_FRA;
        end else begin
          cmd.save_g = 1'b1;
          state_nxt  = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.put       = 1'b1;
          cmd.put_short = short_r;
          cmd.short_sel = n_r[1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      e_r         <= '0;
      ridx_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      isel_r      <= 1'b0;
      sq_r        <= 1'b0;
      short_r     <= 1'b0;
      sa_r        <= crmm_pkg::SLOT_A;
      sb_r        <= crmm_pkg::SLOT_B;
      sf_r        <= crmm_pkg::SLOT_C;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      e_r         <= e_nxt;
      ridx_r      <= ridx_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      isel_r      <= isel_nxt;
      sq_r        <= sq_nxt;
      short_r     <= short_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      sf_r        <= sf_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/crmm_chk.sv @@
`include "assert_macros.svh"

module crmm_chk #(
  parameter int VALUE_BITS = crmm_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [VALUE_BITS-1:0] out_f_value
);

  // reset leaves no result pending and the input open
  `CRMM_ASSERT_NEXT(a_reset_clear, !rst_n, !out_valid && !in_stall)

  // a taken word keeps the input closed while it is worked on
  `CRMM_ASSERT_NEXT(a_busy_after_accept, rst_n && in_valid && !in_stall, !rst_n || in_stall)

  // no result can appear in the cycle right after a word is taken
  `CRMM_ASSERT_NEXT(a_no_instant_result, rst_n && in_valid && !in_stall, !rst_n || !$rose(out_valid))

  // a stalled result holds
  `CRMM_ASSERT_NEXT(a_out_hold, rst_n && out_valid && out_stall,
                    !rst_n || (out_valid && $stable(out_f_value)))

endmodule

bind coupled_recurrence_mod_matpow crmm_chk #(
  .VALUE_BITS (VALUE_BITS)
) u_crmm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_f_value (out_f_value)
);

@@ tb/sv/coupled_recurrence_mod_matpow_tb.sv @@
`default_nettype none

module coupled_recurrence_mod_matpow_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crmm_pkg::*;

  localparam int VB = 16;
  localparam int EB = 31;

  typedef longint unsigned u64_t;
  typedef u64_t mat_t [DIM][DIM];

  // one input word
  typedef struct {
    logic [EB-1:0] n;
    logic [VB-1:0] f0, f1, f2, g0, g1, g2;
  } term_req_t;

  // one result word
  typedef struct {
    logic [VB-1:0] f;
    logic [VB-1:0] g;
  } term_pair_t;

  // one directed row: config set, request, typed-in result if known
  typedef struct {
    int            cset;
    term_req_t     req;
    bit            typed;
    term_pair_t    res;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_addr = '0;
  logic [VB-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [EB-1:0] in_term_index = '0;
  logic [VB-1:0] in_f_init0 = '0, in_f_init1 = '0, in_f_init2 = '0;
  logic [VB-1:0] in_g_init0 = '0, in_g_init1 = '0, in_g_init2 = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VB-1:0] out_f_value;
  logic [VB-1:0] out_g_value;

  coupled_recurrence_mod_matpow uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_term_index(in_term_index),
    .in_f_init0(in_f_init0), .in_f_init1(in_f_init1), .in_f_init2(in_f_init2),
    .in_g_init0(in_g_init0), .in_g_init1(in_g_init1), .in_g_init2(in_g_init2),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_f_value(out_f_value), .out_g_value(out_g_value)
  );

  always #5 clk = ~clk;

  // shadow copy of the register file, index order as on cfg_addr
  logic [VB-1:0] coef_shadow [NUM_REGS];
  term_pair_t    pending_terms [$];
  int            errors = 0;
  bit            quiet = 1'b0;
  int            stall_left = 0;

  // modular 6x6 product, sums reduced after every term
  function automatic mat_t mat_mul_mod(mat_t a, mat_t b, u64_t m);
    mat_t t;
    u64_t s;
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) begin
        s = 0;
        for (int k = 0; k < DIM; k++) s = (s + (a[i][k] * b[k][j]) % m) % m;
        t[i][j] = s;
      end
    return t;
  endfunction

  // f(n), g(n) mod m from the shadow registers
  function automatic term_pair_t calc_terms(term_req_t r);
    term_pair_t p;
    u64_t m, e, fs, gs;
    u64_t st [DIM];
    mat_t base, acc;
    m = (coef_shadow[REG_MODULUS] == 0) ? 1 : u64_t'(coef_shadow[REG_MODULUS]);
    // state order: f2 f1 f0 g2 g1 g0
    st[0] = r.f2 % m; st[1] = r.f1 % m; st[2] = r.f0 % m;
    st[3] = r.g2 % m; st[4] = r.g1 % m; st[5] = r.g0 % m;
    if (r.n < 3) begin
      p.f = VB'(st[2 - r.n]);
      p.g = VB'(st[5 - r.n]);
      return p;
    end
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) begin
        base[i][j] = 0;
        acc[i][j] = (i == j) ? 1 % m : 0;
      end
    base[0][0] = coef_shadow[0] % m;
    base[0][1] = coef_shadow[1] % m;
    base[0][5] = coef_shadow[2] % m;
    base[3][3] = coef_shadow[3] % m;
    base[3][4] = coef_shadow[4] % m;
    base[3][2] = coef_shadow[5] % m;
    base[1][0] = 1 % m; base[2][1] = 1 % m;
    base[4][3] = 1 % m; base[5][4] = 1 % m;
    e = r.n - 2;
    while (e != 0) begin
      if (e[0]) acc = mat_mul_mod(acc, base, m);
      e = e >> 1;
      if (e != 0) base = mat_mul_mod(base, base, m);
    end
    fs = 0; gs = 0;
    for (int k = 0; k < DIM; k++) begin
      fs = (fs + (acc[0][k] * st[k]) % m) % m;
      gs = (gs + (acc[3][k] * st[k]) % m) % m;
    end
    p.f = VB'(fs);
    p.g = VB'(gs);
    return p;
  endfunction

  // wait until every expected word has come back, then let the block settle
  task automatic drain_results();
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // burst of register writes, one per clock; index 7 goes nowhere
  task automatic write_regs(logic [VB-1:0] vals [NUM_REGS], bit poke_unused);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_BITS'(i);
      cfg_wdata <= vals[i];
      coef_shadow[i] = vals[i];
      @(posedge clk);
    end
    if (poke_unused) begin
      cfg_we <= 1'b1;
      cfg_addr <= '1;
      cfg_wdata <= VB'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // present one word, hold it until taken, record what must come back
  task automatic send_term(term_req_t r, bit typed, term_pair_t res);
    int gap;
    in_valid <= 1'b1;
    in_term_index <= r.n;
    in_f_init0 <= r.f0; in_f_init1 <= r.f1; in_f_init2 <= r.f2;
    in_g_init0 <= r.g0; in_g_init1 <= r.g1; in_g_init2 <= r.g2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_terms.push_back(typed ? res : calc_terms(r));
    // idle burst only when lowering valid, so no low-high pair in one step
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic term_req_t rand_req(bit allow_huge);
    term_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (allow_huge) r.n = EB'($urandom);
    else if (pick < 35) r.n = EB'($urandom_range(0, 2));
    else r.n = EB'($urandom_range(3, 12));
    r.f0 = VB'($urandom); r.f1 = VB'($urandom); r.f2 = VB'($urandom);
    r.g0 = VB'($urandom); r.g1 = VB'($urandom); r.g2 = VB'($urandom);
    return r;
  endfunction

  // result side: random stall bursts, none in the quiet tail
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each taken result word against the oldest expectation
  always @(posedge clk) begin
    term_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_terms.size() == 0) begin
        $error("result word with nothing expected: f=%0d g=%0d", out_f_value, out_g_value);
        errors++;
      end else begin
        want = pending_terms.pop_front();
        if (out_f_value !== want.f) begin
          $error("f_value expected %0d got %0d", want.f, out_f_value);
          errors++;
        end
        if (out_g_value !== want.g) begin
          $error("g_value expected %0d got %0d", want.g, out_g_value);
          errors++;
        end
      end
    end
  end

  // config sets used by the directed table
  logic [VB-1:0] cset_vals [4][NUM_REGS];
  dir_row_t      dir_rows [$];

  function automatic dir_row_t mk_row(int cs, logic [EB-1:0] n, logic [VB-1:0] f0, f1, f2,
                                      logic [VB-1:0] g0, g1, g2, bit typed,
                                      logic [VB-1:0] ef, eg);
    dir_row_t d;
    d.cset = cs;
    d.req.n = n;
    d.req.f0 = f0; d.req.f1 = f1; d.req.f2 = f2;
    d.req.g0 = g0; d.req.g1 = g1; d.req.g2 = g2;
    d.typed = typed;
    d.res.f = ef; d.res.g = eg;
    return d;
  endfunction

  initial begin
    logic [VB-1:0] vals [NUM_REGS];
    term_req_t r;
    term_pair_t none;
    int cur;
    int huge_left;
    none.f = '0; none.g = '0;

    // set 0: reset values, nothing is written
    for (int i = 0; i < NUM_REGS; i++) cset_vals[0][i] = '0;
    cset_vals[0][REG_MODULUS] = 16'd1;
    // set 1: every coefficient and the modulus at the top
    for (int i = 0; i < NUM_REGS; i++) cset_vals[1][i] = 16'hffff;
    // set 2: modulus zero acts as one
    for (int i = 0; i < NUM_REGS; i++) cset_vals[2][i] = 16'h1234 + 16'(i);
    cset_vals[2][REG_MODULUS] = 16'd0;
    // set 3: fibonacci-like coupling, mid modulus
    cset_vals[3] = '{16'd1, 16'd1, 16'd1, 16'd2, 16'd0, 16'd3, 16'd1000};

    // after reset the modulus is one, so every result is zero
    dir_rows.push_back(mk_row(0, 0, 16'hffff, 1, 2, 16'hffff, 4, 5, 1, 0, 0));
    dir_rows.push_back(mk_row(0, 5, 7, 8, 9, 10, 11, 12, 1, 0, 0));
    // top coefficients and modulus, initial values at both extremes
    dir_rows.push_back(mk_row(1, 0, 16'hffff, 16'hfffe, 3, 16'hffff, 6, 7, 1, 0, 0));
    dir_rows.push_back(mk_row(1, 1, 16'h0, 16'hfffe, 3, 4, 16'hfffe, 7, 1, 16'hfffe, 16'hfffe));
    dir_rows.push_back(mk_row(1, 2, 1, 2, 16'hfffe, 4, 5, 0, 1, 16'hfffe, 0));
    dir_rows.push_back(mk_row(1, 3, 16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe,
                              16'hfffe, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 4, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk_row(1, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 31'h7fffffff, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa,
                              16'h1, 16'hfffe, 0, 0, 0));
    // zero modulus behaves like one
    dir_rows.push_back(mk_row(2, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 1, 0, 0));
    dir_rows.push_back(mk_row(2, 9, 3, 4, 5, 6, 7, 8, 1, 0, 0));
    // small coupled cases, predicted
    dir_rows.push_back(mk_row(3, 0, 1500, 2500, 3500, 4500, 5500, 6500, 1, 500, 500));
    dir_rows.push_back(mk_row(3, 2, 1500, 2500, 3500, 4500, 5500, 6500, 1, 500, 500));
    dir_rows.push_back(mk_row(3, 3, 1, 1, 1, 1, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(3, 6, 0, 1, 1, 2, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(3, 12, 5, 0, 9, 0, 7, 0, 0, 0, 0));

    for (int i = 0; i < NUM_REGS; i++) coef_shadow[i] = cset_vals[0][i];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, registers reloaded whenever the set changes
    cur = 0;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].cset != cur) begin
        in_valid <= 1'b0;
        drain_results();
        cur = dir_rows[k].cset;
        vals = cset_vals[cur];
        write_regs(vals, cur == 2);
      end
      send_term(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
    end

    // random phases; a few words use a full-width index
    huge_left = 3;
    for (int ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      drain_results();
      for (int i = 0; i < NUM_REGS; i++) vals[i] = VB'($urandom);
      case (ph)
        0: vals[REG_MODULUS] = 16'hffff;
        1: vals[REG_MODULUS] = 16'd2;
        2: vals[REG_MODULUS] = VB'($urandom_range(3, 300));
        default: ;
      endcase
      write_regs(vals, ph == 1);
      quiet = (ph == 3);
      for (int k = 0; k < 22; k++) begin
        r = rand_req(huge_left > 0 && k == 5 && ph < 3);
        if (huge_left > 0 && k == 5 && ph < 3) huge_left--;
        send_term(r, 1'b0, none);
      end
    end
    in_valid <= 1'b0;
    drain_results();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd200_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
